/* rtl/core/lsof_pkg.sv */
// Package for the laser scan outlier filter: word types, register codes,
// configuration struct and the angle gap helper. No dependencies.
`default_nettype none
package lsof_pkg;

  localparam int WINDOW_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SPREAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANY_FACTOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_FACTOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING  = 3'd4;

  localparam logic [15:0] ANGLE_SPREAD_RST = 16'd100;
  localparam logic signed [15:0] FACTOR_RST = -16'sd256;
  localparam logic signed [16:0] MAX_RANGE_RST = -17'sd1;
  localparam logic [15:0] MIN_SPACING_RST = 16'd50;

  localparam logic [17:0] ANG_FULL = 18'd36000;
  localparam logic [17:0] ANG_BIAS = 18'd72000;
  localparam logic [15:0] ANG_HALF = 16'd18000;
  localparam logic signed [15:0] FACTOR_ONE = 16'sd256;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic signed [15:0] beam_angle;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic               ignore_in;
    logic               scan_end;
  } in_word_t;

  typedef struct packed {
    logic               verdict_ignore;
    logic [15:0]        range_out;
    logic signed [15:0] angle_out;
    logic               run_last;
    logic               scan_last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic signed [15:0] angle;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               ign;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0]        angle_spread;
    logic signed [15:0] any_factor;
    logic signed [15:0] all_factor;
    logic signed [16:0] max_range;
    logic [15:0]        min_spacing;
  } cfg_t;

  typedef struct packed {
    logic in_spread;
    logic usable;
    logic all_fail;
    logic any_pass;
  } nbr_res_t;

  // wrapped magnitude of a - b, in [0, 18000]
  function automatic logic [14:0] ang_gap(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    logic [17:0] u;
    logic [15:0] m;
    d = {a[15], a} - {b[15], b};
    u = ANG_BIAS + {d[16], d};
    for (int i = 0; i < 3; i++) begin
      if (u >= ANG_FULL) u = u - ANG_FULL;
    end
    m = u[15:0];
    if (m > ANG_HALF) m = ANG_FULL[15:0] - m;
    return m[14:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lsof_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lsof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/lsof_nbr_test.sv */
// Neighbour test: angle spread check and both ratio tests of one window entry.
// Depends on lsof_pkg.
`default_nettype none
module lsof_nbr_test (
  input  wire lsof_pkg::cfg_t     cfg_i,
  input  wire logic [15:0]        cur_range_i,
  input  wire logic signed [15:0] cur_angle_i,
  input  wire lsof_pkg::entry_t   nb_i,
  output lsof_pkg::nbr_res_t      res_o
);
  logic [14:0] gap;
  logic [23:0] lhs;
  logic [30:0] prod_all, prod_any;
  logic        same, all_on, any_on, fail_all, fail_any;

  assign gap = lsof_pkg::ang_gap(nb_i.angle, cur_angle_i);
  assign lhs = {cur_range_i, 8'd0};
  assign prod_all = nb_i.range_mm * cfg_i.all_factor[14:0];
  assign prod_any = nb_i.range_mm * cfg_i.any_factor[14:0];
  assign same = (cur_range_i == nb_i.range_mm);
  assign all_on = (cfg_i.all_factor > 16'sd0);
  assign any_on = (cfg_i.any_factor > 16'sd0);

  assign fail_all = !same && ((cfg_i.all_factor >= lsof_pkg::FACTOR_ONE) ?
                    ({7'd0, lhs} > prod_all) : ({7'd0, lhs} < prod_all));
  assign fail_any = !same && ((cfg_i.any_factor >= lsof_pkg::FACTOR_ONE) ?
                    ({7'd0, lhs} > prod_any) : ({7'd0, lhs} < prod_any));

  assign res_o.in_spread = ({1'b0, gap} <= cfg_i.angle_spread);
  assign res_o.usable    = res_o.in_spread && !nb_i.ign;
  assign res_o.all_fail  = all_on && fail_all;
  assign res_o.any_pass  = any_on && !fail_any;
endmodule
`default_nettype wire

/* rtl/core/laser_scan_outlier_filter.sv */
// Laser scan outlier filter top level: sequencer around the window RAM.
// Depends on lsof_pkg, lsof_ram and lsof_nbr_test.
//
// Each input word is written into a circular window RAM as it is accepted. A
// verdict is given once WINDOW later readings are held, or at end of scan.
// One verdict runs the setup steps (address, read, absolute differences,
// x square, y and spacing squares, compare), then walks one entry per cycle
// through the single RAM read port, then writes back and presents the
// result, waiting while the result output is stalled. Early rejects skip the
// walk. An input that causes no verdict leaves the filter idle and ready for
// the next input. There is no clearing pass.
`default_nettype none
module laser_scan_outlier_filter #(
  parameter int WINDOW = lsof_pkg::WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lsof_pkg::in_word_t                in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lsof_pkg::out_word_t                    out_word_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lsof_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lsof_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  localparam int AW = $clog2(2 * WINDOW + 1);
  localparam int IW = $clog2(2 * WINDOW + 2);
  localparam int PW = $clog2(WINDOW + 2);
  localparam int RAM_DEPTH = 1 << AW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_CUR  = 4'd2;
  localparam logic [3:0] ST_SQX  = 4'd3;
  localparam logic [3:0] ST_SQY  = 4'd4;
  localparam logic [3:0] ST_SQS  = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_WALK = 4'd7;
  localparam logic [3:0] ST_VERD = 4'd8;

  lsof_pkg::cfg_t cfg_q;
  logic [3:0] state_q, state_d;
  logic [IW-1:0] count_q, count_d, p_q, p_d, j_q, j_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [AW-1:0] base_q, base_d;
  logic end_q, end_d, have_kept_q, have_kept_d, side_q, side_d;
  logic signed [23:0] kept_x_q, kept_x_d, kept_y_q, kept_y_d;
  lsof_pkg::entry_t cur_q, cur_d;
  logic [24:0] ax_q, ax_d, ay_q, ay_d;
  logic [49:0] sq_q, sq_d;
  logic [50:0] d2_q, d2_d;
  logic rej_q, rej_d, ga_q, ga_d, gany_q, gany_d;
  logic out_valid_q, out_valid_d;
  lsof_pkg::out_word_t out_q, out_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  lsof_pkg::entry_t ram_wdata, ram_rdata;
  logic [IW-1:0] rd_lidx;
  lsof_pkg::nbr_res_t nres;

  logic signed [24:0] dx, dy;
  logic [49:0] ay_sq;
  logic [31:0] sp_sq;
  logic [IW-1:0] p_now;
  logic [PW-1:0] pend_n;
  logic can_emit, ign, more, drop;
  logic [IW-1:0] p_inc, j_inc;

  lsof_ram #(.WIDTH(lsof_pkg::ENTRY_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lsof_nbr_test u_nbr (
    .cfg_i       (cfg_q),
    .cur_range_i (cur_q.range_mm),
    .cur_angle_i (cur_q.angle),
    .nb_i        (ram_rdata),
    .res_o       (nres)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign p_now = count_q - IW'(pend_q);
  assign p_inc = p_q + IW'(1);
  assign j_inc = j_q + IW'(1);
  assign ram_raddr = AW'(base_q + rd_lidx[AW-1:0]);
  assign dx = {cur_q.x[23], cur_q.x} - {kept_x_q[23], kept_x_q};
  assign dy = {cur_q.y[23], cur_q.y} - {kept_y_q[23], kept_y_q};
  assign ay_sq = ay_q * ay_q;
  assign sp_sq = cfg_q.min_spacing * cfg_q.min_spacing;
  assign can_emit = !out_valid_q || out_ready_i;
  assign ign = rej_q || !(ga_q && gany_q);
  assign pend_n = pend_q - PW'(1);
  assign more = (pend_n > PW'(WINDOW)) || (end_q && (pend_n != '0));
  assign drop = ((count_q - IW'(pend_n)) > IW'(WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_spread <= lsof_pkg::ANGLE_SPREAD_RST;
      cfg_q.any_factor   <= lsof_pkg::FACTOR_RST;
      cfg_q.all_factor   <= lsof_pkg::FACTOR_RST;
      cfg_q.max_range    <= lsof_pkg::MAX_RANGE_RST;
      cfg_q.min_spacing  <= lsof_pkg::MIN_SPACING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsof_pkg::REG_ANGLE_SPREAD: cfg_q.angle_spread <= cfg_data_i[15:0];
        lsof_pkg::REG_ANY_FACTOR:   cfg_q.any_factor   <= cfg_data_i[15:0];
        lsof_pkg::REG_ALL_FACTOR:   cfg_q.all_factor   <= cfg_data_i[15:0];
        lsof_pkg::REG_MAX_RANGE:    cfg_q.max_range    <= cfg_data_i;
        lsof_pkg::REG_MIN_SPACING:  cfg_q.min_spacing  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pend_d = pend_q;
    base_d = base_q;
    end_d = end_q;
    have_kept_d = have_kept_q;
    kept_x_d = kept_x_q;
    kept_y_d = kept_y_q;
    side_d = side_q;
    p_d = p_q;
    j_d = j_q;
    cur_d = cur_q;
    ax_d = ax_q;
    ay_d = ay_q;
    sq_d = sq_q;
    d2_d = d2_q;
    rej_d = rej_q;
    ga_d = ga_q;
    gany_d = gany_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    ram_we = 1'b0;
    ram_waddr = AW'(base_q + count_q[AW-1:0]);
    ram_wdata = '0;
    rd_lidx = p_now;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_we = 1'b1;
          ram_wdata.range_mm = in_word_i.range_mm;
          ram_wdata.angle    = in_word_i.beam_angle;
          ram_wdata.x        = in_word_i.hit_x;
          ram_wdata.y        = in_word_i.hit_y;
          ram_wdata.ign      = in_word_i.ignore_in;
          count_d = count_q + IW'(1);
          pend_d = pend_q + PW'(1);
          end_d = in_word_i.scan_end;
          if ((pend_d > PW'(WINDOW)) || in_word_i.scan_end) state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        p_d = p_now;
        state_d = ST_CUR;
      end
      ST_CUR: begin
        cur_d = ram_rdata;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        ax_d = dx[24] ? 25'(-dx) : 25'(dx);
        ay_d = dy[24] ? 25'(-dy) : 25'(dy);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        sq_d = ax_q * ax_q;
        state_d = ST_SQS;
      end
      ST_SQS: begin
        d2_d = {1'b0, sq_q} + {1'b0, ay_sq};
        sq_d = {18'd0, sp_sq};
        state_d = ST_CMP;
      end
      ST_CMP: begin
        rej_d = cur_q.ign
             || (!cfg_q.max_range[16] && (cur_q.range_mm > cfg_q.max_range[15:0]))
             || (have_kept_q && (d2_q < {1'b0, sq_q}));
        ga_d = 1'b1;
        gany_d = (cfg_q.any_factor <= 16'sd0);
        if (rej_d) begin
          state_d = ST_VERD;
        end else if (p_q != '0) begin
          rd_lidx = p_q - IW'(1);
          j_d = rd_lidx;
          side_d = 1'b0;
          state_d = ST_WALK;
        end else if (p_inc < count_q) begin
          rd_lidx = p_inc;
          j_d = rd_lidx;
          side_d = 1'b1;
          state_d = ST_WALK;
        end else begin
          state_d = ST_VERD;
        end
      end
      ST_WALK: begin
        if (nres.usable) begin
          if (nres.all_fail) ga_d = 1'b0;
          if (nres.any_pass) gany_d = 1'b1;
        end
        if (!side_q && nres.in_spread && (j_q != '0)) begin
          rd_lidx = j_q - IW'(1);
          j_d = rd_lidx;
        end else if (!side_q && (p_inc < count_q)) begin
          rd_lidx = p_inc;
          j_d = rd_lidx;
          side_d = 1'b1;
        end else if (side_q && nres.in_spread && (j_inc < count_q)) begin
          rd_lidx = j_inc;
          j_d = rd_lidx;
        end else begin
          state_d = ST_VERD;
        end
      end
      ST_VERD: begin
        if (can_emit) begin
          ram_we = 1'b1;
          ram_waddr = AW'(base_q + p_q[AW-1:0]);
          ram_wdata = cur_q;
          ram_wdata.ign = ign;
          out_valid_d = 1'b1;
          out_d.verdict_ignore = ign;
          out_d.range_out = cur_q.range_mm;
          out_d.angle_out = cur_q.angle;
          out_d.run_last = !more;
          out_d.scan_last = !more && end_q;
          if (!ign) begin
            have_kept_d = 1'b1;
            kept_x_d = cur_q.x;
            kept_y_d = cur_q.y;
          end
          pend_d = pend_n;
          if (drop) begin
            base_d = base_q + AW'(1);
            count_d = count_q - IW'(1);
          end
          if (more) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
            if (end_q) begin
              count_d = '0;
              pend_d = '0;
              have_kept_d = 1'b0;
              kept_x_d = '0;
              kept_y_d = '0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q <= '0;
      base_q <= '0;
      end_q <= 1'b0;
      have_kept_q <= 1'b0;
      kept_x_q <= '0;
      kept_y_q <= '0;
      side_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q <= pend_d;
      base_q <= base_d;
      end_q <= end_d;
      have_kept_q <= have_kept_d;
      kept_x_q <= kept_x_d;
      kept_y_q <= kept_y_d;
      side_q <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    j_q <= j_d;
    cur_q <= cur_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    sq_q <= sq_d;
    d2_q <= d2_d;
    rej_q <= rej_d;
    ga_q <= ga_d;
    gany_q <= gany_d;
    out_q <= out_d;
  end
endmodule
`default_nettype wire

/* rtl/core/lsof_checker.sv */
// Port-level checks for the laser scan outlier filter, bound to the top level.
// Depends on lsof_pkg and laser_scan_outlier_filter.
`default_nettype none
module lsof_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire lsof_pkg::in_word_t              in_word_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire lsof_pkg::out_word_t             out_word_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_scan_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.scan_last |-> out_word_o.run_last)
    else $error("scan_last without run_last");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.scan_end |=> !in_ready_o)
    else $error("input taken before end-of-scan flush");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.run_last |-> !in_ready_o)
    else $error("input offered in the middle of a run");
endmodule

bind laser_scan_outlier_filter lsof_checker u_lsof_checker (.*);
`default_nettype wire

/* verif/tb_laser_scan_outlier_filter.sv */
// Self-checking testbench for laser_scan_outlier_filter: directed and random scans with bursty
// input and stalled output, verdicts checked against a predictor kept in the bench.
// Depends on lsof_pkg and the laser_scan_outlier_filter RTL.
module tb_laser_scan_outlier_filter;

  localparam int WIN = 16;
  localparam int SLOTS = 2 * WIN + 1;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lsof_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lsof_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [lsof_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsof_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  laser_scan_outlier_filter uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial forever #1 clk_i = ~clk_i;

  // filter settings as the predictor sees them
  int spread_cd = 100;
  int any_q8 = -256;
  int all_q8 = -256;
  int range_cap = -1;
  int spacing_mm = 50;

  // predictor window, oldest first
  logic [15:0] w_rng [SLOTS];
  logic [15:0] w_ang [SLOTS];
  int w_x [SLOTS];
  int w_y [SLOTS];
  bit w_ign [SLOTS];
  int held = 0;
  int waiting = 0;
  int last_x = 0;
  int last_y = 0;
  bit kept_any = 0;

  lsof_pkg::in_word_t readings [$];
  lsof_pkg::out_word_t verdicts_due [$];
  int errors = 0;
  int fed = 0;
  int judged = 0;
  int rejected = 0;
  int phases = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit held_once = 0;
  int cyc = 0;

  function automatic int wrap_gap(logic [15:0] a, logic [15:0] b);
    int d;
    int m;
    d = int'($signed(a)) - int'($signed(b));
    m = d % 36000;
    if (m < 0) m += 36000;
    if (m > 18000) m = 36000 - m;
    return m;
  endfunction

  function automatic bit ratio_pass(int r, int o, int f);
    longint lhs;
    longint rhs;
    if (r == o || f <= 0) return 1;
    lhs = longint'(r) * 256;
    rhs = longint'(o) * f;
    if (f >= 256) return !(lhs > rhs);
    return !(lhs < rhs);
  endfunction

  function automatic void weigh(int p, int j, ref bit ok_all, ref bit ok_any);
    if (w_ign[j]) return;
    if (all_q8 > 0 && !ratio_pass(w_rng[p], w_rng[j], all_q8)) ok_all = 0;
    if (any_q8 > 0 && ratio_pass(w_rng[p], w_rng[j], any_q8)) ok_any = 1;
  endfunction

  function automatic bit rejects(int p);
    bit ok_all;
    bit ok_any;
    longint dx;
    longint dy;
    ok_all = 1;
    ok_any = (any_q8 <= 0);
    if (w_ign[p]) return 1;
    if (range_cap >= 0 && int'(w_rng[p]) > range_cap) return 1;
    if (kept_any) begin
      dx = longint'(w_x[p]) - last_x;
      dy = longint'(w_y[p]) - last_y;
      if (dx * dx + dy * dy < longint'(spacing_mm) * spacing_mm) return 1;
    end
    for (int j = p; j > 0; j--) begin
      if (wrap_gap(w_ang[j-1], w_ang[p]) > spread_cd) break;
      weigh(p, j - 1, ok_all, ok_any);
    end
    for (int j = p + 1; j < held; j++) begin
      if (wrap_gap(w_ang[j], w_ang[p]) > spread_cd) break;
      weigh(p, j, ok_all, ok_any);
    end
    return !(ok_all && ok_any);
  endfunction

  function automatic void predict_verdicts(lsof_pkg::in_word_t w);
    lsof_pkg::out_word_t res [$];
    lsof_pkg::out_word_t o;
    int p;
    bit ign;
    w_rng[held] = w.range_mm;
    w_ang[held] = w.beam_angle;
    w_x[held] = int'(w.hit_x);
    w_y[held] = int'(w.hit_y);
    w_ign[held] = w.ignore_in;
    held++;
    waiting++;
    while (waiting > WIN || (w.scan_end && waiting > 0)) begin
      p = held - waiting;
      ign = rejects(p);
      w_ign[p] = ign;
      if (!ign) begin
        kept_any = 1;
        last_x = w_x[p];
        last_y = w_y[p];
      end
      o = '0;
      o.verdict_ignore = ign;
      o.range_out = w_rng[p];
      o.angle_out = w_ang[p];
      res.insert(res.size(), o);
      waiting--;
      if (held - waiting > WIN) begin
        for (int i = 0; i < held - 1; i++) begin
          w_rng[i] = w_rng[i+1];
          w_ang[i] = w_ang[i+1];
          w_x[i] = w_x[i+1];
          w_y[i] = w_y[i+1];
          w_ign[i] = w_ign[i+1];
        end
        held--;
      end
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last = 1'b1;
      res[res.size()-1].scan_last = w.scan_end;
    end
    if (w.scan_end) begin
      held = 0;
      waiting = 0;
      kept_any = 0;
      last_x = 0;
      last_y = 0;
    end
    foreach (res[i]) verdicts_due.insert(verdicts_due.size(), res[i]);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at verdict %0d: %s got %0d expected %0d", judged, what, got, want);
    errors++;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (readings.size() > 0) begin
        in_valid <= 1'b1;
        in_word <= readings.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      cyc++;
      if (!held_once && judged >= 150) begin
        held_once = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if ((cyc / 256) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // predictor feed, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        predict_verdicts(in_word);
        fed++;
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (verdicts_due.size() == 0) begin
          $display("unexpected verdict for range %0d", out_word.range_out);
          errors++;
        end else begin
          lsof_pkg::out_word_t e;
          e = verdicts_due.pop_front();
          if (out_word.verdict_ignore !== e.verdict_ignore)
            report("verdict_ignore", out_word.verdict_ignore, e.verdict_ignore);
          if (out_word.range_out !== e.range_out)
            report("range_out", out_word.range_out, e.range_out);
          if (out_word.angle_out !== e.angle_out)
            report("angle_out", out_word.angle_out, e.angle_out);
          if (out_word.run_last !== e.run_last)
            report("run_last", out_word.run_last, e.run_last);
          if (out_word.scan_last !== e.scan_last)
            report("scan_last", out_word.scan_last, e.scan_last);
          if (e.verdict_ignore) rejected++;
        end
        judged++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic set_reg(logic [lsof_pkg::CFG_IDX_W-1:0] idx, int value);
    logic [lsof_pkg::CFG_DATA_W-1:0] d;
    d = value[lsof_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      lsof_pkg::REG_ANGLE_SPREAD: spread_cd = int'(d[15:0]);
      lsof_pkg::REG_ANY_FACTOR: any_q8 = int'($signed(d[15:0]));
      lsof_pkg::REG_ALL_FACTOR: all_q8 = int'($signed(d[15:0]));
      lsof_pkg::REG_MAX_RANGE: range_cap = int'($signed(d));
      lsof_pkg::REG_MIN_SPACING: spacing_mm = int'(d[15:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (readings.size() == 0 && !in_valid && verdicts_due.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic int pick_factor();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 256;
      4: return -int'($urandom_range(1, 500));
      default: return $urandom_range(64, 700);
    endcase
  endfunction

  task automatic random_settings();
    case ($urandom_range(0, 4))
      0: set_reg(lsof_pkg::REG_ANGLE_SPREAD, 0);
      1: set_reg(lsof_pkg::REG_ANGLE_SPREAD, 36000);
      2: set_reg(lsof_pkg::REG_ANGLE_SPREAD, 18000);
      default: set_reg(lsof_pkg::REG_ANGLE_SPREAD, $urandom_range(20, 600));
    endcase
    set_reg(lsof_pkg::REG_ANY_FACTOR, pick_factor());
    set_reg(lsof_pkg::REG_ALL_FACTOR, pick_factor());
    case ($urandom_range(0, 4))
      0: set_reg(lsof_pkg::REG_MAX_RANGE, -1);
      1: set_reg(lsof_pkg::REG_MAX_RANGE, 0);
      2: set_reg(lsof_pkg::REG_MAX_RANGE, 65535);
      default: set_reg(lsof_pkg::REG_MAX_RANGE, $urandom_range(2000, 60000));
    endcase
    case ($urandom_range(0, 5))
      0: set_reg(lsof_pkg::REG_MIN_SPACING, 0);
      1: set_reg(lsof_pkg::REG_MIN_SPACING, 65535);
      default: set_reg(lsof_pkg::REG_MIN_SPACING, $urandom_range(0, 150));
    endcase
    if ($urandom_range(0, 3) == 0) set_reg(3'd5 + 3'($urandom_range(0, 2)), $urandom);
    phases++;
  endtask

  task automatic queue_scan();
    lsof_pkg::in_word_t w;
    int n;
    int ang;
    int rng;
    int x;
    int y;
    bit noise;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 24);
    noise = ($urandom_range(0, 9) == 0);
    ang = $urandom_range(0, 36000) - 18000;
    rng = $urandom_range(500, 60000);
    x = $urandom_range(0, 200000) - 100000;
    y = $urandom_range(0, 200000) - 100000;
    for (int i = 0; i < n; i++) begin
      w = '0;
      ang += $urandom_range(0, 120);
      if (ang > 18000) ang -= 36000;
      x += $urandom_range(0, 160) - 80;
      y += $urandom_range(0, 160) - 80;
      rng += $urandom_range(0, 400) - 200;
      if (rng < 0) rng = 0;
      if (rng > 65535) rng = 65535;
      w.beam_angle = ang[15:0];
      w.range_mm = ($urandom_range(0, 7) == 0) ? 16'($urandom) : rng[15:0];
      w.hit_x = x[23:0];
      w.hit_y = y[23:0];
      w.ignore_in = ($urandom_range(0, 9) == 0);
      if (noise || $urandom_range(0, 19) == 0) begin
        w.beam_angle = 16'($urandom);
        w.hit_x = 24'($urandom);
        w.hit_y = 24'($urandom);
        w.range_mm = 16'($urandom);
      end
      w.scan_end = (i == n - 1);
      readings.insert(readings.size(), w);
    end
  endtask

  task automatic add_reading(int r, int a, int x, int y, bit ign, bit last);
    lsof_pkg::in_word_t w;
    w.range_mm = r[15:0];
    w.beam_angle = a[15:0];
    w.hit_x = x[23:0];
    w.hit_y = y[23:0];
    w.ignore_in = ign;
    w.scan_end = last;
    readings.insert(readings.size(), w);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: default settings, single reading scan
    add_reading(1000, 0, 0, 0, 0, 1);
    drain();
    set_reg(lsof_pkg::REG_ANGLE_SPREAD, 500);
    set_reg(lsof_pkg::REG_ANY_FACTOR, 384);
    set_reg(lsof_pkg::REG_ALL_FACTOR, 128);
    set_reg(lsof_pkg::REG_MAX_RANGE, 60000);
    set_reg(lsof_pkg::REG_MIN_SPACING, 10);
    set_reg(3'd7, 12345);
    phases++;
    add_reading(0, -18000, -8388608, -8388608, 0, 0);
    add_reading(65535, 18000, 8388607, 8388607, 0, 0);
    add_reading(1000, 17900, 0, 0, 0, 0);
    add_reading(1000, -17950, 5, 5, 0, 0);
    add_reading(1100, -17800, 100, 0, 1, 0);
    add_reading(3000, -17700, 200, 0, 0, 0);
    add_reading(1050, 32767, 300, 0, 0, 0);
    add_reading(1020, -32768, 400, 0, 0, 0);
    add_reading(60001, 0, 500, 0, 0, 0);
    add_reading(60000, 50, 600, 0, 0, 0);
    add_reading(900, 100, 603, 4, 0, 0);
    add_reading(950, 150, 700, 0, 0, 1);
    drain();
    set_reg(lsof_pkg::REG_ANY_FACTOR, 256);
    set_reg(lsof_pkg::REG_ALL_FACTOR, 512);
    set_reg(lsof_pkg::REG_ANGLE_SPREAD, 18000);
    for (int i = 0; i < 20; i++)
      add_reading(2000 + 37 * i, 1000 * i - 9000, 100 * i, -100 * i, i == 7, i == 19);
    drain();
    while (fed < 430) begin
      random_settings();
      repeat ($urandom_range(2, 4)) queue_scan();
      drain();
    end
    $display("%0d readings over %0d settings, %0d verdicts (%0d rejected)",
             fed, phases, judged, rejected);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* laser_scan_outlier_filter.f */
rtl/core/lsof_pkg.sv
rtl/core/lsof_ram.sv
rtl/core/lsof_nbr_test.sv
rtl/core/laser_scan_outlier_filter.sv
rtl/core/lsof_checker.sv
verif/tb_laser_scan_outlier_filter.sv
